// File: src/lcd_4bit_write_sequencer_unit_assert.svh
// Assertion macros shared by the LCD sequencer RTL.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef LCD_4BIT_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define LCD_4BIT_WRITE_SEQUENCER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCD4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcd4: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LCD4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcd4: next-cycle check failed");

`endif

// File: src/lcd4_pkg.sv
package lcd4_pkg;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SETUP,
    PH_HIGH,
    PH_POST
  } phase_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POST_PULSE_WAIT = 2'd0;
  localparam logic [1:0] CFG_HOME_CLEAR_WAIT = 2'd1;

  // Reset values of the timing registers and the power-up wait.
  localparam logic [7:0]  POST_PULSE_WAIT_RST = 8'd45;
  localparam logic [15:0] HOME_CLEAR_WAIT_RST = 16'd2000;
  localparam logic [15:0] POWER_UP_WAIT_RST   = 16'd20000;

  // Init sequence: four single nibbles, then five bytes.
  localparam logic [3:0] INIT_NIBBLES = 4'd4;
  localparam logic [3:0] INIT_DONE    = 4'd9;

  // One request on the input channel.
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
    logic       is_character;
  } item_t;

  // One result on the output channel.
  typedef struct packed {
    logic [3:0] data_nibble;
    logic       register_select;
    logic       enable_pin;
    logic       busy_res;
    logic       rejected;
  } result_t;

  // Sequencer state.
  typedef struct packed {
    phase_e      phase;
    logic [15:0] wait_count;
    logic [3:0]  init_step;
    logic [7:0]  held_byte;
    logic        held_is_char;
    logic        low_half_next;
    logic [3:0]  pin_nibble;
    logic        pin_rs;
    logic        pin_enable;
  } state_t;

  // Extra wait after each of the four init nibbles.
  function automatic logic [15:0] init_extra(logic [1:0] idx);
    logic [15:0] val;
    unique case (idx)
      2'd0:    val = 16'd5000;
      2'd1:    val = 16'd200;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

  // Instruction bytes of the init sequence.
  function automatic logic [7:0] init_byte(logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h28;
      3'd1:    val = 8'h08;
      3'd2:    val = 8'h01;
      3'd3:    val = 8'h0C;
      3'd4:    val = 8'h80;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: src/lcd4_req_if.sv
interface lcd4_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;
  logic       is_character;

  modport source (output valid, mode, byte_value, is_character, input ready);
  modport sink   (input valid, mode, byte_value, is_character, output ready);
endinterface

// File: src/lcd4_res_if.sv
interface lcd4_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       register_select;
  logic       enable_pin;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, data_nibble, register_select, enable_pin, busy_res,
                  rejected, input ready);
  modport sink   (input valid, data_nibble, register_select, enable_pin, busy_res,
                  rejected, output ready);
endinterface

// File: src/lcd4_core.sv
module lcd4_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lcd4_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output lcd4_pkg::result_t result_o
);

  lcd4_pkg::state_t state_q, state_d;
  logic [7:0]       post_wait_q;
  logic [15:0]      home_wait_q;
  logic             rejected;

  // Put one nibble on the pins and start its set-up tick.
  function automatic lcd4_pkg::state_t put_nibble(lcd4_pkg::state_t s, logic [3:0] nib,
                                                  logic rs);
    lcd4_pkg::state_t r;
    r = s;
    r.pin_nibble = nib;
    r.pin_rs     = rs;
    r.pin_enable = 1'b0;
    r.phase      = lcd4_pkg::PH_SETUP;
    return r;
  endfunction

  // Latch a byte and send its high nibble.
  function automatic lcd4_pkg::state_t start_byte(lcd4_pkg::state_t s, logic [7:0] b,
                                                  logic ch);
    lcd4_pkg::state_t r;
    r = s;
    r.held_byte     = b;
    r.held_is_char  = ch;
    r.low_half_next = 1'b0;
    return put_nibble(r, b[7:4], ch);
  endfunction

  // Start whatever follows a finished init nibble or byte.
  function automatic lcd4_pkg::state_t proceed(lcd4_pkg::state_t s);
    lcd4_pkg::state_t r;
    logic [7:0]       b;
    r = s;
    b = 8'h00;
    if (r.init_step < lcd4_pkg::INIT_NIBBLES) begin
      r = put_nibble(r, (r.init_step < 4'd3) ? 4'h3 : 4'h2, 1'b0);
    end else if (r.init_step < lcd4_pkg::INIT_DONE) begin
      b = lcd4_pkg::init_byte(3'(r.init_step - lcd4_pkg::INIT_NIBBLES));
      r.init_step = r.init_step + 4'd1;
      r = start_byte(r, b, 1'b0);
    end else begin
      r.phase = lcd4_pkg::PH_IDLE;
    end
    return r;
  endfunction

  // An extra wait; a zero wait moves on in the same item.
  function automatic lcd4_pkg::state_t extra_wait(lcd4_pkg::state_t s, logic [15:0] n);
    lcd4_pkg::state_t r;
    r = s;
    if (n == 16'd0) begin
      r = proceed(r);
    end else begin
      r.phase      = lcd4_pkg::PH_WAIT;
      r.wait_count = n;
    end
    return r;
  endfunction

  // The post-pulse wait of a nibble has ended.
  function automatic lcd4_pkg::state_t nibble_done(lcd4_pkg::state_t s, logic [15:0] hcw);
    lcd4_pkg::state_t r;
    logic [15:0]      e;
    r = s;
    e = 16'd0;
    if (r.init_step < lcd4_pkg::INIT_NIBBLES) begin
      e = lcd4_pkg::init_extra(r.init_step[1:0]);
      r.init_step = r.init_step + 4'd1;
      r = extra_wait(r, e);
    end else if (!r.low_half_next) begin
      r.low_half_next = 1'b1;
      r = put_nibble(r, r.held_byte[3:0], r.held_is_char);
    end else begin
      r.low_half_next = 1'b0;
      e = (!r.held_is_char && (r.held_byte < 8'd4)) ? hcw : 16'd0;
      r = extra_wait(r, e);
    end
    return r;
  endfunction

  // Advance the sequencer by one microsecond tick.
  function automatic lcd4_pkg::state_t tick(lcd4_pkg::state_t s, logic [7:0] ppw,
                                            logic [15:0] hcw);
    lcd4_pkg::state_t r;
    r = s;
    unique case (s.phase)
      lcd4_pkg::PH_WAIT, lcd4_pkg::PH_POST: begin
        if (r.wait_count != 16'd0) begin
          r.wait_count = r.wait_count - 16'd1;
        end
        if (r.wait_count == 16'd0) begin
          r = (s.phase == lcd4_pkg::PH_WAIT) ? proceed(r) : nibble_done(r, hcw);
        end
      end
      lcd4_pkg::PH_SETUP: begin
        r.pin_enable = 1'b1;
        r.phase      = lcd4_pkg::PH_HIGH;
      end
      lcd4_pkg::PH_HIGH: begin
        r.pin_enable = 1'b0;
        r.wait_count = {8'd0, ppw};
        if (ppw == 8'd0) begin
          r = nibble_done(r, hcw);
        end else begin
          r.phase = lcd4_pkg::PH_POST;
        end
      end
      default: begin
        r.phase = lcd4_pkg::PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // Next state for the request at hand; a write while busy leaves the state alone.
  always_comb begin
    state_d  = state_q;
    rejected = 1'b0;
    if (item_i.mode) begin
      if (state_q.phase != lcd4_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        state_d = start_byte(state_q, item_i.byte_value, item_i.is_character);
      end
    end else begin
      state_d = tick(state_q, post_wait_q, home_wait_q);
    end
  end

  // Pin levels after the request is handled.
  always_comb begin
    result_o.data_nibble     = state_d.pin_nibble;
    result_o.register_select = state_d.pin_rs;
    result_o.enable_pin      = state_d.pin_enable;
    result_o.busy_res        = (state_d.phase != lcd4_pkg::PH_IDLE);
    result_o.rejected        = rejected;
  end

  // Sequencer state; reset starts the power-up wait.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= lcd4_pkg::PH_WAIT;
      state_q.wait_count    <= lcd4_pkg::POWER_UP_WAIT_RST;
      state_q.init_step     <= 4'd0;
      state_q.held_byte     <= 8'd0;
      state_q.held_is_char  <= 1'b0;
      state_q.low_half_next <= 1'b0;
      state_q.pin_nibble    <= 4'd0;
      state_q.pin_rs        <= 1'b0;
      state_q.pin_enable    <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  // Timing registers. The power-up wait starts at reset with its reset value,
  // so it has no register here; a write to any index other than the two timing registers is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_wait_q <= lcd4_pkg::POST_PULSE_WAIT_RST;
      home_wait_q <= lcd4_pkg::HOME_CLEAR_WAIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lcd4_pkg::CFG_POST_PULSE_WAIT) begin
        post_wait_q <= cfg_wdata_i[7:0];
      end
      if (cfg_idx_i == lcd4_pkg::CFG_HOME_CLEAR_WAIT) begin
        home_wait_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: src/lcd_4bit_write_sequencer_unit.sv
// Pipeline: an accepted request is held in the input register; its result is then captured
// in the result register once that register is free or being emptied by res_o.ready.
// Throughput: one request per cycle while the result side is ready; the sequencer state advances once per request.
// Reset (asynchronous, active low) clears the valid flags of both pipeline registers, loads the timing
// registers with their defaults and starts the power-up wait of 20000 ticks.
`include "lcd_4bit_write_sequencer_unit_assert.svh"

module lcd_4bit_write_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcd4_req_if.sink    req_i,
  lcd4_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic               in_valid_q;
  lcd4_pkg::item_t    in_q;
  logic               out_valid_q;
  lcd4_pkg::result_t  res_q;
  lcd4_pkg::result_t  res_d;
  logic               advance;

  // A held request moves on when the result register is free or being emptied.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.mode         <= req_i.mode;
      in_q.byte_value   <= req_i.byte_value;
      in_q.is_character <= req_i.is_character;
    end
  end

  lcd4_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.data_nibble     = res_q.data_nibble;
  assign res_o.register_select = res_q.register_select;
  assign res_o.enable_pin      = res_q.enable_pin;
  assign res_o.busy_res        = res_q.busy_res;
  assign res_o.rejected        = res_q.rejected;

  // A request that moves on always lands in the result register.
  `LCD4_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_q)
  // A held request that cannot move on stays held.
  `LCD4_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q)
  // Only a busy sequencer rejects a write.
  `LCD4_ASSERT_NOW(a_rej_busy, out_valid_q && res_q.rejected, res_q.busy_res)
  // The strobe is only high in the middle of a transfer.
  `LCD4_ASSERT_NOW(a_en_busy, out_valid_q && res_q.enable_pin, res_q.busy_res)

endmodule
